FILE: rtl/core/combined_lcg_shuffle_rng_macros.svh
// Assertion macros for the combined generator checker.
// Needs a clk and an rst signal in the scope of each use.
`ifndef COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH
`define COMBINED_LCG_SHUFFLE_RNG_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CLSR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CLSR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/clsr_pkg.sv
// Shared types and constants for the combined generator with shuffle table.
// No dependencies; used by the modular step unit and the top level.
`default_nettype none

package clsr_pkg;

  // Word width of generator states, table entries and samples.
  localparam int SMP_W  = 31;
  // Width of the generator multipliers and of the modulus fold constants.
  localparam int MUL_W  = 16;
  localparam int FOLD_W = 8;

  localparam logic [SMP_W-1:0]  MOD1 = 31'd2147483563;
  localparam logic [SMP_W-1:0]  MOD2 = 31'd2147483399;
  localparam logic [MUL_W-1:0]  MUL1 = 16'd40014;
  localparam logic [MUL_W-1:0]  MUL2 = 16'd40692;
  // 2^31 minus each modulus, used to fold the high product bits back in.
  localparam logic [FOLD_W-1:0] FOLD1 = 8'd85;
  localparam logic [FOLD_W-1:0] FOLD2 = 8'd249;

  localparam logic [31:0]       WRAP_ADD     = 32'd2147483562;
  localparam logic [SMP_W-1:0]  GEN2_INIT    = 31'd123456789;
  localparam int                WARMUP_EXTRA = 8;

  // Which generator a modular step unit serves.
  typedef enum logic {
    GEN_ONE,
    GEN_TWO
  } gen_sel_t;

  // Control of one modular step unit.
  typedef struct packed {
    logic     load;
    gen_sel_t sel;
  } mm_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/clsr_mulmod.sv
// Modular step x <- mul * x mod m for either generator, product registered.
// Depends on clsr_pkg for constants and the control struct.
`default_nettype none

module clsr_mulmod (
  input  logic                          clk,
  input  clsr_pkg::mm_ctrl_t            ctrl,
  input  logic [clsr_pkg::SMP_W-1:0]    x,
  output logic [clsr_pkg::SMP_W-1:0]    result
);
  import clsr_pkg::*;

  localparam int PROD_W = SMP_W + MUL_W;
  localparam int HF_W   = MUL_W + FOLD_W;

  logic [MUL_W-1:0]  mul_c;
  logic [FOLD_W-1:0] fold_c;
  logic [SMP_W-1:0]  mod_c;
  logic [PROD_W-1:0] prod;
  logic [HF_W-1:0]   hi_fold;
  logic [SMP_W:0]    fsum;

  // Constants of the selected generator.
  always_comb begin
    unique case (ctrl.sel)
      GEN_ONE: begin
        mul_c  = MUL1;
        fold_c = FOLD1;
        mod_c  = MOD1;
      end
      GEN_TWO: begin
        mul_c  = MUL2;
        fold_c = FOLD2;
        mod_c  = MOD2;
      end
      default: begin
        mul_c  = MUL1;
        fold_c = FOLD1;
        mod_c  = MOD1;
      end
    endcase
  end

  // Product stage: the full product is registered on load.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      prod <= PROD_W'(x) * PROD_W'(mul_c);
    end
  end

  // Reduction from the registered product: since 2^31 is congruent to the fold
  // constant, the high bits fold into the low word; the sum stays below twice
  // the modulus, so one conditional subtract finishes the reduction.
  assign hi_fold = HF_W'(prod[PROD_W-1:SMP_W]) * HF_W'(fold_c);
  assign fsum    = {1'b0, prod[SMP_W-1:0]} + (SMP_W+1)'(hi_fold);

  always_comb begin
    if (fsum >= {1'b0, mod_c}) begin
      result = SMP_W'(fsum - {1'b0, mod_c});
    end else begin
      result = fsum[SMP_W-1:0];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/combined_lcg_shuffle_rng.sv
// Combined two-generator random source with a shuffle table in a synchronous
// memory. A draw word goes through the two generator products, registered on
// acceptance, then their reduction and the read of the chosen table slot, and
// then forming the sample and writing the slot back, which waits while a
// stalled result holds the output register. A reseed, or a draw that finds
// the first generator at zero (as the first draw after reset does), adds a
// warm-up of TABLE_SIZE+8 generator steps on the shared first-generator step
// unit before the draw. One word is in work at a time; a finished result
// waits in the output register while the next word is accepted. The table
// needs no clearing pass: every slot is written by the warm-up before any draw reads it.
`default_nettype none

module combined_lcg_shuffle_rng #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          mode,
  input  logic [clsr_pkg::SMP_W-1:0]    seed_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [clsr_pkg::SMP_W-1:0]    sample,
  output logic [clsr_pkg::SMP_W-1:0]    gen1_word
);
  import clsr_pkg::*;

  localparam int SLOT_W   = $clog2(TABLE_SIZE);
  localparam int IDX_W    = $clog2(TABLE_SIZE + 1);
  localparam int J_W      = $clog2(TABLE_SIZE + WARMUP_EXTRA);
  localparam int R_W      = SLOT_W + 2;
  localparam int RECIP_SH = 31;
  localparam int QP_W     = SMP_W + R_W;
  localparam logic [63:0] SLOT_DIV = 64'd1 + 64'(WRAP_ADD) / 64'(TABLE_SIZE);
  localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / SLOT_DIV;
  localparam logic [J_W-1:0] J_LAST = J_W'(TABLE_SIZE + WARMUP_EXTRA - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WMUL,
    ST_WRED,
    ST_DMUL,
    ST_DRED,
    ST_FIN
  } state_t;

  state_t            state;
  logic [SMP_W-1:0]  gen1;
  logic [SMP_W-1:0]  gen2;
  logic [SMP_W-1:0]  last_sample;
  logic [J_W-1:0]    j;
  logic [SLOT_W-1:0] q0;
  logic [SLOT_W-1:0] slot_r;

  logic              acc;
  logic              reseed_go;
  logic [SMP_W-1:0]  seed_fix;
  logic              out_free;
  mm_ctrl_t          mm1_ctrl;
  mm_ctrl_t          mm2_ctrl;
  logic [SMP_W-1:0]  red1;
  logic [SMP_W-1:0]  red2;

  logic [QP_W-1:0]   q_prod;
  logic [SLOT_W-1:0] q0_next;
  logic [SMP_W:0]    thr_tab [TABLE_SIZE+1];
  logic [IDX_W-1:0]  q0p1;
  logic              bump;
  logic [SLOT_W-1:0] slot;

  logic [31:0]       diff;
  logic [SMP_W-1:0]  sample_next;

  logic [SMP_W-1:0]  shuf_mem [TABLE_SIZE];
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  logic [SMP_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [SMP_W-1:0]  mem_rdata;

  // Input handshake and reseed decision.
  assign in_stall  = (state != ST_IDLE);
  assign acc       = in_valid && !in_stall;
  assign reseed_go = mode || (gen1 == '0);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    if (mode && (seed_value != '0)) begin
      seed_fix = seed_value;
    end else begin
      seed_fix = SMP_W'(1);
    end
  end

  // Step unit controls: the first unit also runs every warm-up step.
  always_comb begin
    mm1_ctrl.sel  = GEN_ONE;
    mm2_ctrl.sel  = GEN_TWO;
    mm1_ctrl.load = (acc && !reseed_go) || (state == ST_WMUL) || (state == ST_DMUL);
    mm2_ctrl.load = (acc && !reseed_go) || (state == ST_DMUL);
  end

  clsr_mulmod u_mm1 (
    .clk    (clk),
    .ctrl   (mm1_ctrl),
    .x      (gen1),
    .result (red1)
  );

  clsr_mulmod u_mm2 (
    .clk    (clk),
    .ctrl   (mm2_ctrl),
    .x      (gen2),
    .result (red2)
  );

  // Slot boundaries k * SLOT_DIV as a constant table.
  for (genvar k = 0; k <= TABLE_SIZE; k++) begin : g_thr
    assign thr_tab[k] = (SMP_W+1)'(64'(k) * SLOT_DIV);
  end

  // Slot estimate by reciprocal multiply; it is exact or one low.
  assign q_prod  = QP_W'(last_sample) * QP_W'(RECIP[R_W-1:0]);
  assign q0_next = q_prod[RECIP_SH +: SLOT_W];

  always_ff @(posedge clk) begin
    q0 <= q0_next;
  end

  // Correction against the next boundary gives the exact slot.
  assign q0p1 = IDX_W'(q0) + IDX_W'(1);
  assign bump = ({1'b0, last_sample} >= thr_tab[q0p1]);
  assign slot = q0 + SLOT_W'(bump);

  // Slot content minus the second generator, wrapped into range when not positive.
  always_comb begin
    diff = {1'b0, mem_rdata} - {1'b0, gen2};
    if (mem_rdata <= gen2) begin
      diff = diff + WRAP_ADD;
    end
    sample_next = diff[SMP_W-1:0];
  end

  // Table port control: warm-up fills, draws read one slot and refill it.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot_r;
    mem_wdata = gen1;
    mem_re    = (state == ST_DRED);
    unique case (state)
      ST_WRED: begin
        mem_we    = (j < J_W'(TABLE_SIZE));
        mem_waddr = j[SLOT_W-1:0];
        mem_wdata = red1;
      end
      ST_FIN: begin
        mem_we = out_free;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Shuffle table memory with registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      shuf_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= shuf_mem[slot];
    end
  end

  // Sequencer, generator state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      gen1        <= '0;
      gen2        <= GEN2_INIT;
      last_sample <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The result register loads a finished word or drops the taken one.
      if ((state == ST_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (acc) begin
            if (reseed_go) begin
              gen1  <= seed_fix;
              gen2  <= seed_fix;
              j     <= J_LAST;
              state <= ST_WMUL;
            end else begin
              state <= ST_DRED;
            end
          end
        end
        ST_WMUL: begin
          state <= ST_WRED;
        end
        ST_WRED: begin
          gen1 <= red1;
          if (j == '0) begin
            last_sample <= red1;
            state       <= ST_DMUL;
          end else begin
            j     <= j - J_W'(1);
            state <= ST_WMUL;
          end
        end
        ST_DMUL: begin
          state <= ST_DRED;
        end
        ST_DRED: begin
          gen1   <= red1;
          gen2   <= red2;
          slot_r <= slot;
          state  <= ST_FIN;
        end
        ST_FIN: begin
          if (out_free) begin
            last_sample <= sample_next;
            sample      <= sample_next;
            gen1_word   <= gen1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clsr_checker.sv
// Port-level assertions for the combined generator, bound to the top level.
// Depends on combined_lcg_shuffle_rng_macros.svh.
`default_nettype none
`include "combined_lcg_shuffle_rng_macros.svh"

module clsr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [30:0] sample,
  input logic [30:0] gen1_word
);

  // Samples always land in the wrapped range.
  `CLSR_ASSERT_NOW(a_sample_range, out_valid, (sample >= 31'd1) && (sample <= 31'd2147483562), "sample out of range")

  // The first generator word is always reduced below its modulus.
  `CLSR_ASSERT_NOW(a_gen1_range, out_valid, gen1_word <= 31'd2147483562, "gen1_word not reduced")

  // One word at a time: an accepted word blocks the input on the next cycle.
  `CLSR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open right after accept")

  // No result can appear in the cycle after a word is accepted.
  `CLSR_ASSERT_NEXT(a_no_early_result, in_valid && !in_stall && !out_valid, !out_valid, "result too early")

  // A stalled result holds.
  `CLSR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(sample) && $stable(gen1_word), "stalled result changed")

endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (.*);

`default_nettype wire

FILE: tb/rng_draw_checker.sv
`timescale 1ns / 1ps
// Result checker for the combined two-generator random source with shuffle table.
// Mirrors generator state and table, predicts each result word, compares it.
// Depends on clsr_pkg for word widths and generator constants.
module rng_draw_checker #(
  parameter int TABLE_SIZE = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       mode,
  input  logic [clsr_pkg::SMP_W-1:0] seed_value,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [clsr_pkg::SMP_W-1:0] sample,
  input  logic [clsr_pkg::SMP_W-1:0] gen1_word,
  output int                         fail_count,
  output int                         words_in_flight
);
  import clsr_pkg::*;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic [SMP_W-1:0] gen1_word;
  } draw_word_t;

  // Width of the value range covered by one table slot.
  localparam logic [31:0] SLOT_SPAN = 32'd1 + WRAP_ADD / 32'(TABLE_SIZE);

  // Mirrored generator state and shuffle table.
  logic [SMP_W-1:0] gen1_q;
  logic [SMP_W-1:0] gen2_q;
  logic [SMP_W-1:0] last_q;
  logic [SMP_W-1:0] shuffle_q [TABLE_SIZE];

  draw_word_t expected_draws [$];
  int         result_no;

  // One multiplicative congruential step, exact product reduced by the modulus.
  function automatic logic [SMP_W-1:0] mod_step(input logic [SMP_W-1:0] x,
                                                input logic [MUL_W-1:0] mul,
                                                input logic [SMP_W-1:0] modulus);
    logic [63:0] prod;
    prod = 64'(x) * 64'(mul);
    return SMP_W'(prod % 64'(modulus));
  endfunction

  // Reseed both generators and run the warm-up that fills the table top down.
  function automatic void reseed_state(input logic [SMP_W-1:0] seed);
    gen1_q = (seed == '0) ? SMP_W'(1) : seed;
    gen2_q = gen1_q;
    for (int j = TABLE_SIZE + WARMUP_EXTRA - 1; j >= 0; j--) begin
      gen1_q = mod_step(gen1_q, MUL1, MOD1);
      if (j < TABLE_SIZE) begin
        shuffle_q[j] = gen1_q;
      end
    end
    last_q = shuffle_q[0];
  endfunction

  // Advance the mirrored state by one accepted word and return its result.
  function automatic draw_word_t predict_draw(input logic reseed_req,
                                              input logic [SMP_W-1:0] seed);
    int unsigned slot;
    longint      diff;
    draw_word_t  res;
    // An unseeded first generator forces a reseed with one.
    if (reseed_req) begin
      reseed_state(seed);
    end else if (gen1_q == '0) begin
      reseed_state(SMP_W'(1));
    end
    gen1_q = mod_step(gen1_q, MUL1, MOD1);
    gen2_q = mod_step(gen2_q, MUL2, MOD2);
    slot = (32'(last_q) / SLOT_SPAN) % TABLE_SIZE;
    diff = longint'({33'd0, shuffle_q[slot]}) - longint'({33'd0, gen2_q});
    shuffle_q[slot] = gen1_q;
    if (diff < 1) begin
      diff += longint'(WRAP_ADD);
    end
    last_q = diff[SMP_W-1:0];
    res.sample = last_q;
    res.gen1_word = gen1_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [SMP_W-1:0] got,
                                 input logic [SMP_W-1:0] want);
    $display("%0t: result %0d: %s: got %0d, expected %0d", $time, result_no, what,
             got, want);
    fail_count++;
  endtask

  // Predict on every accepted input word, compare on every accepted result word.
  always @(posedge clk) begin
    draw_word_t want;
    if (rst) begin
      gen1_q = '0;
      gen2_q = GEN2_INIT;
      last_q = '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        shuffle_q[i] = '0;
      end
      expected_draws.delete();
      result_no = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_draws.push_back(predict_draw(mode, seed_value));
      end
      if (out_valid && !out_stall) begin
        if (expected_draws.size() == 0) begin
          report_mismatch("result word with nothing expected", sample, '0);
        end else begin
          want = expected_draws.pop_front();
          if (sample !== want.sample) begin
            report_mismatch("sample", sample, want.sample);
          end
          if (gen1_word !== want.gen1_word) begin
            report_mismatch("gen1_word", gen1_word, want.gen1_word);
          end
        end
        result_no++;
      end
    end
    words_in_flight <= expected_draws.size();
  end

endmodule

FILE: tb/combined_lcg_shuffle_rng_tb.sv
`timescale 1ns / 1ps
// Testbench top for the combined two-generator random source: clock, reset,
// word sender with bursts and gaps, stalling receiver and the final verdict.
// Depends on clsr_pkg, the block itself and rng_draw_checker.
module combined_lcg_shuffle_rng_tb;
  import clsr_pkg::*;

  localparam int TABLE_SIZE = 32;
  localparam logic MODE_DRAW   = 1'b0;
  localparam logic MODE_RESEED = 1'b1;
  localparam logic [SMP_W-1:0] SEED_MAX = '1;
  localparam int RANDOM_WORDS    = 1050;
  localparam int RESEED_PCT      = 8;
  localparam int HOLD_OFF_START  = 1500;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_CYCLES    = 120;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_stall;
  logic             mode;
  logic [SMP_W-1:0] seed_value;
  logic             out_valid;
  logic             out_stall;
  logic [SMP_W-1:0] sample;
  logic [SMP_W-1:0] gen1_word;
  int               fail_count;
  int               words_in_flight;

  combined_lcg_shuffle_rng #(
    .TABLE_SIZE(TABLE_SIZE)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .seed_value(seed_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample),
    .gen1_word(gen1_word)
  );

  rng_draw_checker #(
    .TABLE_SIZE(TABLE_SIZE)
  ) checker_i (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .mode(mode),
    .seed_value(seed_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sample(sample),
    .gen1_word(gen1_word),
    .fail_count(fail_count),
    .words_in_flight(words_in_flight)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one word and hold it until the block takes it.
  task automatic offer_word(input logic m, input logic [SMP_W-1:0] s);
    in_valid <= 1'b1;
    mode <= m;
    seed_value <= s;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Reseed values lean on zero, the all-ones word and both moduli.
  function automatic logic [SMP_W-1:0] pick_seed();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SEED_MAX;
      2: return MOD1;
      3: return MOD2;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  // Sender: directed words first, then random bursts with gaps.
  initial begin : sender
    int sent;
    int burst;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_DRAW;
    seed_value = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A draw straight after reset has to seed itself with one.
    offer_word(MODE_DRAW, SEED_MAX);
    offer_word(MODE_DRAW, '0);
    offer_word(MODE_RESEED, '0);
    offer_word(MODE_DRAW, '0);
    pause_sender($urandom_range(1, 3));
    offer_word(MODE_RESEED, SMP_W'(1));
    offer_word(MODE_RESEED, SEED_MAX);
    offer_word(MODE_DRAW, SEED_MAX);
    // Seeding with the first modulus zeroes generator one, so the next draw reseeds.
    offer_word(MODE_RESEED, MOD1);
    offer_word(MODE_DRAW, '0);
    offer_word(MODE_DRAW, '0);
    pause_sender($urandom_range(1, 3));
    // Seeding with the second modulus pins generator two at zero.
    offer_word(MODE_RESEED, MOD2);
    offer_word(MODE_DRAW, '0);
    offer_word(MODE_DRAW, SEED_MAX);
    offer_word(MODE_RESEED, MOD1 - 1'b1);
    offer_word(MODE_RESEED, MOD2 - 1'b1);
    offer_word(MODE_DRAW, '0);
    offer_word(MODE_RESEED, 31'h4000_0000);
    offer_word(MODE_DRAW, 31'h2AAA_AAAA);
    offer_word(MODE_RESEED, 31'h2AAA_AAAA);
    offer_word(MODE_RESEED, 31'h5555_5555);
    offer_word(MODE_DRAW, 31'h5555_5555);
    pause_sender($urandom_range(1, 5));

    // Random part: mostly draws with noise in the ignored seed field.
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = $urandom_range(1, 40);
      for (int b = 0; b < burst && sent < RANDOM_WORDS; b++) begin
        if ($urandom_range(0, 99) < RESEED_PCT) begin
          offer_word(MODE_RESEED, pick_seed());
        end else begin
          offer_word(MODE_DRAW, SMP_W'($urandom));
        end
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        pause_sender($urandom_range(1, 12));
      end
    end
    in_valid <= 1'b0;

    // Drain: the count is registered in the checker, so read it only after the last word is counted.
    @(posedge clk);
    while (words_in_flight != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Receiver: stretches of differing stall density, and one long hold-off
  // that backs the block up into its input.
  initial begin : receiver
    int  stretch;
    int  stall_pct;
    int  cycle_no;
    bit  held_off;
    out_stall = 1'b0;
    held_off = 1'b0;
    cycle_no = 0;
    wait (!rst);
    forever begin
      stretch = $urandom_range(5, 60);
      case ($urandom_range(0, 3))
        0: stall_pct = 0;
        1: stall_pct = 30;
        2: stall_pct = 60;
        default: stall_pct = 90;
      endcase
      if (!held_off && cycle_no >= HOLD_OFF_START) begin
        held_off = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        cycle_no += HOLD_OFF_CYCLES;
      end
      repeat (stretch) begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
        @(posedge clk);
        cycle_no++;
      end
    end
  end

  // Watchdog well beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/clsr_pkg.sv
rtl/core/clsr_mulmod.sv
rtl/core/combined_lcg_shuffle_rng.sv
rtl/core/clsr_checker.sv
tb/rng_draw_checker.sv
tb/combined_lcg_shuffle_rng_tb.sv
